// ----- src/dmp_cfg_pkg.sv -----
package dmp_cfg_pkg;

  typedef enum logic [2:0] {
    PhBank    = 3'd0,
    PhOffset  = 3'd1,
    PhLength  = 3'd2,
    PhData    = 3'd3,
    PhSpecial = 3'd4,
    PhDiscard = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KindMem   = 2'd0,
    KindReg   = 2'd1,
    KindBadSp = 2'd2,
    KindTrunc = 2'd3
  } kind_e;

  localparam logic [7:0] CodeIntEnable  = 8'h01;
  localparam logic [7:0] IntEnableValue = 8'h32;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_stream;
  } item_t;

  typedef struct packed {
    logic       present;
    kind_e      kind;
    logic [4:0] bank;
    logic [7:0] address;
    logic [7:0] data;
    logic       done;
  } result_t;

endpackage

// ----- src/dmp_cfg_in_reg.sv -----
module dmp_cfg_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dmp_cfg_pkg::item_t   item_i,
  input  logic                 move_i,
  output logic                 valid_o,
  output dmp_cfg_pkg::item_t   item_o
);
  import dmp_cfg_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  load;

  assign in_stall_o = valid_q & ~move_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (move_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

endmodule

// ----- src/dmp_cfg_decode.sv -----
module dmp_cfg_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 move_i,
  input  dmp_cfg_pkg::item_t   item_i,
  output dmp_cfg_pkg::result_t result_o
);
  import dmp_cfg_pkg::*;

  phase_e     phase_q, phase_d;
  logic [4:0] bank_q, bank_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] left_q, left_d;
  logic [7:0] b;
  logic       eos;

  assign b   = item_i.stream_byte;
  assign eos = item_i.end_of_stream;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhBank;
      bank_q  <= '0;
      addr_q  <= '0;
      left_q  <= '0;
    end else if (move_i) begin
      phase_q <= phase_d;
      bank_q  <= bank_d;
      addr_q  <= addr_d;
      left_q  <= left_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    bank_d   = bank_q;
    addr_d   = addr_q;
    left_d   = left_q;
    result_o = '{present: 1'b0, kind: KindMem, bank: 5'd0, address: 8'd0,
                 data: 8'd0, done: eos};
    case (phase_q)
      PhOffset: begin
        addr_d  = b;
        phase_d = PhLength;
        if (eos) begin
          result_o.present = 1'b1;
          result_o.kind    = KindTrunc;
        end
      end
      PhLength: begin
        if (b != 8'd0) begin
          left_d  = b;
          phase_d = PhData;
        end else begin
          phase_d = PhSpecial;
        end
        if (eos) begin
          result_o.present = 1'b1;
          result_o.kind    = KindTrunc;
        end
      end
      PhData: begin
        result_o.present = 1'b1;
        if (eos && left_q != 8'd1) begin
          result_o.kind = KindTrunc;
        end else begin
          result_o.kind    = KindMem;
          result_o.bank    = bank_q;
          result_o.address = addr_q;
          result_o.data    = b;
          addr_d = addr_q + 8'd1;
          if (addr_q == 8'hFF) begin
            bank_d = bank_q + 5'd1;
          end
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) begin
            phase_d = PhBank;
          end
        end
      end
      PhSpecial: begin
        result_o.present = 1'b1;
        if (b == CodeIntEnable) begin
          result_o.kind = KindReg;
          result_o.data = IntEnableValue;
          phase_d       = PhBank;
        end else begin
          result_o.kind = KindBadSp;
          result_o.data = b;
          phase_d       = PhDiscard;
        end
      end
      PhDiscard: begin
        phase_d = PhDiscard;
      end
      default: begin
        bank_d  = b[4:0];
        phase_d = PhOffset;
        if (eos) begin
          result_o.present = 1'b1;
          result_o.kind    = KindTrunc;
        end
      end
    endcase
    if (eos) begin
      phase_d = PhBank;
      bank_d  = '0;
      addr_d  = '0;
      left_d  = '0;
    end
  end

endmodule

// ----- src/dmp_cfg_out_reg.sv -----
module dmp_cfg_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 move_i,
  input  dmp_cfg_pkg::result_t result_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output dmp_cfg_pkg::result_t result_o
);
  import dmp_cfg_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (move_i) begin
      valid_q <= result_i.present;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_i) begin
      result_q <= result_i;
    end
  end

endmodule

// ----- src/dmp_config_stream_writer_core.sv -----
// A transfer is held in the input register, decoded, and its result held in
// the result register. Throughput: one byte per cycle while the output does
// not stall; the two registers each hold one transfer, so one more transfer is
// taken while a result waits, then the input stalls until the result leaves.
// Reset (rst_ni, asynchronous, active low): both registers empty, decoder back
// to expecting a bank byte with bank, address and byte count cleared.
module dmp_config_stream_writer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] stream_byte_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [4:0] bank_out_o,
  output logic [7:0] address_out_o,
  output logic [7:0] data_out_o,
  output logic       stream_done_o
);
  import dmp_cfg_pkg::*;

  item_t   in_item;
  item_t   reg_item;
  logic    reg_valid;
  logic    move;
  result_t step_result;
  result_t out_result;

  assign in_item.stream_byte   = stream_byte_i;
  assign in_item.end_of_stream = end_of_stream_i;

  // advance when the result register is free or drains this cycle
  assign move = reg_valid & (~out_valid_o | ~out_stall_i);

  dmp_cfg_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .move_i     (move),
    .valid_o    (reg_valid),
    .item_o     (reg_item)
  );

  dmp_cfg_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .move_i   (move),
    .item_i   (reg_item),
    .result_o (step_result)
  );

  dmp_cfg_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .move_i      (move),
    .result_i    (step_result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (out_result)
  );

  assign kind_o        = out_result.kind;
  assign bank_out_o    = out_result.bank;
  assign address_out_o = out_result.address;
  assign data_out_o    = out_result.data;
  assign stream_done_o = out_result.done;

endmodule
